// ===== hw/rtl/wsmv_pkg.sv =====
// ----------------------------------------------------------------------------
// wsmv_pkg: shared types and constants of the WAV mono volume stream block
// Holds the result codes, the header layout, the parser phases and the
// word types that pass between the parser and the scaling pipeline.
// ----------------------------------------------------------------------------
package wsmv_pkg;

   localparam logic [2:0] KIND_SAMPLE = 3'd0;
   localparam logic [2:0] KIND_ACCEPT = 3'd1;
   localparam logic [2:0] KIND_BADTAG = 3'd2;
   localparam logic [2:0] KIND_BADFMT = 3'd3;
   localparam logic [2:0] KIND_SHORT  = 3'd4;

   localparam logic [5:0] HEADER_LEN   = 6'd44;
   localparam logic [5:0] POS_RIFF_END = 6'd4;
   localparam logic [5:0] POS_WAVE     = 6'd8;
   localparam logic [5:0] POS_WAVE_END = 6'd12;
   localparam logic [5:0] POS_CHAN_LO  = 6'd22;
   localparam logic [5:0] POS_CHAN_HI  = 6'd23;
   localparam logic [5:0] POS_RATE     = 6'd24;
   localparam logic [5:0] POS_RATE_END = 6'd28;
   localparam logic [5:0] POS_BITS_LO  = 6'd34;
   localparam logic [5:0] POS_BITS_HI  = 6'd35;
   localparam logic [5:0] POS_SIZE     = 6'd40;

   localparam logic [15:0] SUPPORTED_BITS = 16'd16;
   localparam logic [15:0] CHANNELS_MONO  = 16'd1;
   localparam logic [15:0] CHANNELS_STEREO = 16'd2;

   localparam logic [6:0] VOLUME_RESET = 7'd50;
   localparam logic [6:0] VOLUME_LIMIT = 7'd100;

   // Division by 100 as a multiply by floor(2^22 / 100) and one correction.
   localparam logic [15:0] RECIP_100   = 16'd41943;
   localparam int          RECIP_SHIFT = 22;
   localparam logic [22:0] DIVISOR     = 23'd100;

   localparam logic signed [16:0] SAMPLE_MAX = 17'sd32767;
   localparam logic signed [16:0] SAMPLE_MIN = -17'sd32768;

   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_DATA   = 3'b010,
      PH_IDLE   = 3'b100
   } phase_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] rate_hz;
      logic [15:0] channels;
      logic [15:0] depth_bits;
      logic [31:0] chunk_size;
   } hdr_type;

   typedef struct packed {
      hdr_type            hdr;
      logic signed [15:0] mixed;
   } res_type;

   function automatic logic [7:0] riff_byte(input logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0: b = 8'h52;
         2'd1: b = 8'h49;
         2'd2: b = 8'h46;
         2'd3: b = 8'h46;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] wave_byte(input logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0: b = 8'h57;
         2'd1: b = 8'h41;
         2'd2: b = 8'h56;
         2'd3: b = 8'h45;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [31:0] put_byte32(input logic [31:0] val,
                                              input logic [1:0] idx,
                                              input logic [7:0] b);
      logic [31:0] r;
      r = val;
      unique case (idx)
         2'd0: r[7:0]   = b;
         2'd1: r[15:8]  = b;
         2'd2: r[23:16] = b;
         2'd3: r[31:24] = b;
         default: r = val;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/wsmv_ifs.sv =====
// ----------------------------------------------------------------------------
// wsmv_ifs: handshake channels of the WAV mono volume stream block
// Byte input channel, result channel and volume register write channel.
// ----------------------------------------------------------------------------
interface wsmv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       file_start;
   logic       file_end;

   modport source (output valid, data_byte, file_start, file_end, input ready);
   modport sink (input valid, data_byte, file_start, file_end, output ready);
endinterface

interface wsmv_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic signed [15:0] sample;
   logic [31:0]        rate_hz;
   logic [15:0]        channels;
   logic [15:0]        depth_bits;
   logic [31:0]        chunk_size;

   modport source (output valid, kind, sample, rate_hz, channels,
                   depth_bits, chunk_size, input ready);
   modport sink (input valid, kind, sample, rate_hz, channels,
                 depth_bits, chunk_size, output ready);
endinterface

interface wsmv_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] volume_percent;

   modport source (output valid, volume_percent, input ready);
   modport sink (input valid, volume_percent, output ready);
endinterface

// ===== hw/rtl/wsmv_parse.sv =====
// ----------------------------------------------------------------------------
// wsmv_parse: header parser and frame assembler
// Walks the 44-byte header, checks tags and format, then gathers frame bytes
// and mixes stereo frames down to one sample. Results land in a register.
// ----------------------------------------------------------------------------
module wsmv_parse import wsmv_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  logic [7:0] data_byte,
   input  logic    file_start,
   input  logic    file_end,
   output logic    res_valid,
   input  logic    res_ready,
   output res_type res_data
);

   logic [5:0]  pos_ff, pos_in;
   phase_type   phase_ff, phase_in;
   logic        tags_ff, tags_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] size_ff, size_in;
   logic [1:0]  fbi_ff, fbi_in;
   logic [23:0] fbytes_ff, fbytes_in;

   logic        res_valid_ff, res_valid_in;
   res_type     res_ff, res_in;

   logic        accept;
   logic        has_res;
   logic [5:0]  pos_next;
   logic [31:0] chan_wide;
   logic [31:0] bits_wide;
   logic        stereo;
   logic        frame_done;
   logic signed [15:0] left;
   logic signed [15:0] right;
   logic signed [16:0] sum;
   logic signed [16:0] half;
   logic [2:0]  kind;

   assign in_ready = !res_valid_ff || res_ready;
   assign accept   = in_valid && in_ready;

   always_comb begin
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      tags_in   = tags_ff;
      chan_in   = chan_ff;
      rate_in   = rate_ff;
      bits_in   = bits_ff;
      size_in   = size_ff;
      fbi_in    = fbi_ff;
      fbytes_in = fbytes_ff;
      has_res   = 1'b0;
      kind      = KIND_SAMPLE;
      res_in    = '0;
      pos_next  = '0;
      chan_wide = '0;
      bits_wide = '0;
      stereo    = 1'b0;
      frame_done = 1'b0;
      left      = '0;
      right     = '0;
      sum       = '0;
      half      = '0;
      if (accept) begin
         if (file_start) begin
            pos_in    = '0;
            phase_in  = PH_HEADER;
            tags_in   = 1'b1;
            chan_in   = '0;
            rate_in   = '0;
            bits_in   = '0;
            size_in   = '0;
            fbi_in    = '0;
            fbytes_in = '0;
         end
         unique case (phase_in)
            PH_HEADER: begin
               chan_wide = {16'd0, chan_in};
               bits_wide = {16'd0, bits_in};
               priority if (pos_in < POS_RIFF_END) begin
                  if (data_byte != riff_byte(pos_in[1:0])) tags_in = 1'b0;
               end else if (pos_in >= POS_WAVE && pos_in < POS_WAVE_END) begin
                  if (data_byte != wave_byte(pos_in[1:0])) tags_in = 1'b0;
               end else if (pos_in == POS_CHAN_LO || pos_in == POS_CHAN_HI) begin
                  chan_wide = put_byte32(chan_wide, {1'b0, pos_in[0]}, data_byte);
               end else if (pos_in >= POS_RATE && pos_in < POS_RATE_END) begin
                  rate_in = put_byte32(rate_in, pos_in[1:0], data_byte);
               end else if (pos_in == POS_BITS_LO || pos_in == POS_BITS_HI) begin
                  bits_wide = put_byte32(bits_wide, {1'b0, pos_in[0]}, data_byte);
               end else if (pos_in >= POS_SIZE) begin
                  size_in = put_byte32(size_in, pos_in[1:0], data_byte);
               end else begin
                  tags_in = tags_in;
               end
               chan_in  = chan_wide[15:0];
               bits_in  = bits_wide[15:0];
               pos_next = pos_in + 6'd1;
               pos_in   = pos_next;
               if (pos_next == HEADER_LEN) begin
                  if (!tags_in) begin
                     kind = KIND_BADTAG;
                  end else if (bits_in != SUPPORTED_BITS ||
                               (chan_in != CHANNELS_MONO &&
                                chan_in != CHANNELS_STEREO)) begin
                     kind = KIND_BADFMT;
                  end else begin
                     kind = KIND_ACCEPT;
                  end
                  phase_in  = (kind == KIND_ACCEPT && !file_end) ? PH_DATA : PH_IDLE;
                  fbi_in    = '0;
                  fbytes_in = '0;
                  has_res   = 1'b1;
               end else if (file_end) begin
                  phase_in = PH_IDLE;
                  kind     = KIND_SHORT;
                  has_res  = 1'b1;
               end
               res_in.hdr.kind       = kind;
               res_in.hdr.rate_hz    = rate_in;
               res_in.hdr.channels   = chan_in;
               res_in.hdr.depth_bits = bits_in;
               res_in.hdr.chunk_size = size_in;
               res_in.mixed          = '0;
            end
            PH_DATA: begin
               stereo     = (chan_in == CHANNELS_STEREO);
               frame_done = stereo ? (fbi_in == 2'd3) : (fbi_in != 2'd0);
               if (!frame_done) begin
                  unique case (fbi_in)
                     2'd0: fbytes_in[7:0]   = data_byte;
                     2'd1: fbytes_in[15:8]  = data_byte;
                     2'd2: fbytes_in[23:16] = data_byte;
                     2'd3: fbytes_in = fbytes_in;
                     default: fbytes_in = fbytes_in;
                  endcase
                  fbi_in = fbi_in + 2'd1;
               end else begin
                  left  = fbytes_in[15:0];
                  right = {data_byte, fbytes_in[23:16]};
                  sum   = 17'(left) + 17'(right);
                  half  = (sum + {16'd0, sum[16]}) >>> 1;
                  res_in.hdr.kind = KIND_SAMPLE;
                  res_in.mixed = stereo ? half[15:0] : {data_byte, fbytes_in[7:0]};
                  fbi_in    = '0;
                  fbytes_in = '0;
                  has_res   = 1'b1;
               end
               if (file_end) phase_in = PH_IDLE;
            end
            PH_IDLE: begin
               has_res = 1'b0;
            end
            default: begin
               has_res = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      if (accept) begin
         res_valid_in = has_res;
      end else begin
         res_valid_in = res_valid_ff && !res_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         phase_ff     <= PH_HEADER;
         tags_ff      <= 1'b1;
         chan_ff      <= '0;
         rate_ff      <= '0;
         bits_ff      <= '0;
         size_ff      <= '0;
         fbi_ff       <= '0;
         fbytes_ff    <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         tags_ff      <= tags_in;
         chan_ff      <= chan_in;
         rate_ff      <= rate_in;
         bits_ff      <= bits_in;
         size_ff      <= size_in;
         fbi_ff       <= fbi_in;
         fbytes_ff    <= fbytes_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && has_res) begin
         res_ff <= res_in;
      end
   end

   assign res_valid = res_valid_ff;
   assign res_data  = res_ff;

endmodule

// ===== hw/rtl/wsmv_scale.sv =====
// ----------------------------------------------------------------------------
// wsmv_scale: volume scaling pipeline
// Multiplies the mixed sample by the volume, divides by 100 through a
// reciprocal multiply and one correction, saturates and holds the result.
// ----------------------------------------------------------------------------
module wsmv_scale import wsmv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [6:0] volume,
   input  logic       in_valid,
   output logic       in_ready,
   input  res_type    in_data,
   wsmv_rsp_if.source rsp_if
);

   logic        s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;
   logic        s2_ready, s3_ready, s4_ready, out_ready;
   logic        s2_load, s3_load, s4_load, out_load;

   hdr_type     s2_hdr_ff, s3_hdr_ff, s4_hdr_ff, out_hdr_ff;
   logic [21:0] s2_mag_ff, s3_mag_ff;
   logic        s2_neg_ff, s3_neg_ff, s4_neg_ff;
   logic [15:0] s3_q0_ff, s4_q_ff;
   logic signed [15:0] out_sample_ff;

   logic [21:0] s2_mag_in;
   logic [15:0] s3_q0_in;
   logic [15:0] s4_q_in;
   logic signed [15:0] out_sample_in;

   logic [6:0]         vol_clamped;
   logic signed [7:0]  vol_signed;
   logic signed [23:0] product;
   logic [23:0]        mag_full;
   logic [37:0]        recip;
   logic [22:0]        back;
   logic [22:0]        rem;
   logic signed [16:0] signed_q;

   assign out_ready = !out_valid_ff || rsp_if.ready;
   assign s4_ready  = !s4_valid_ff || out_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign in_ready  = s2_ready;

   assign s2_load  = in_valid && s2_ready;
   assign s3_load  = s2_valid_ff && s3_ready;
   assign s4_load  = s3_valid_ff && s4_ready;
   assign out_load = s4_valid_ff && out_ready;

   always_comb begin
      vol_clamped = (volume > VOLUME_LIMIT) ? VOLUME_LIMIT : volume;
      vol_signed  = {1'b0, vol_clamped};
      product     = in_data.mixed * vol_signed;
      mag_full    = product[23] ? 24'(-product) : product;
      s2_mag_in   = mag_full[21:0];

      recip    = 38'(s2_mag_ff) * 38'(RECIP_100);
      s3_q0_in = recip[37:RECIP_SHIFT];

      back    = 23'(s3_q0_ff) * DIVISOR;
      rem     = 23'(s3_mag_ff) - back;
      s4_q_in = (rem >= DIVISOR) ? s3_q0_ff + 16'd1 : s3_q0_ff;

      signed_q = s4_neg_ff ? -$signed({1'b0, s4_q_ff}) : $signed({1'b0, s4_q_ff});
      priority if (signed_q > SAMPLE_MAX) begin
         out_sample_in = SAMPLE_MAX[15:0];
      end else if (signed_q < SAMPLE_MIN) begin
         out_sample_in = SAMPLE_MIN[15:0];
      end else begin
         out_sample_in = signed_q[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s2_ready) s2_valid_ff <= in_valid;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
         if (out_ready) out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_hdr_ff <= in_data.hdr;
         s2_mag_ff <= s2_mag_in;
         s2_neg_ff <= product[23];
      end
      if (s3_load) begin
         s3_hdr_ff <= s2_hdr_ff;
         s3_mag_ff <= s2_mag_ff;
         s3_neg_ff <= s2_neg_ff;
         s3_q0_ff  <= s3_q0_in;
      end
      if (s4_load) begin
         s4_hdr_ff <= s3_hdr_ff;
         s4_neg_ff <= s3_neg_ff;
         s4_q_ff   <= s4_q_in;
      end
      if (out_load) begin
         out_hdr_ff    <= s4_hdr_ff;
         out_sample_ff <= out_sample_in;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.kind       = out_hdr_ff.kind;
   assign rsp_if.sample     = out_sample_ff;
   assign rsp_if.rate_hz    = out_hdr_ff.rate_hz;
   assign rsp_if.channels   = out_hdr_ff.channels;
   assign rsp_if.depth_bits = out_hdr_ff.depth_bits;
   assign rsp_if.chunk_size = out_hdr_ff.chunk_size;

endmodule

// ===== hw/rtl/wav_stream_mono_volume_top.sv =====
// ----------------------------------------------------------------------------
// wav_stream_mono_volume_top: WAV header parser, mono downmix and volume
// Results pass the parser result register and scaling stages s2, s3, s4 and
// out to rsp. Throughput: one byte word per cycle unless rsp ready stalls;
// the parser register and four scaling stages each take a new word whenever
// the stage after them moves. Reset clears the parser to header byte 0,
// empties the pipeline and sets the volume to 50 percent.
// ----------------------------------------------------------------------------
module wav_stream_mono_volume_top import wsmv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   wsmv_req_if.sink   req_if,
   wsmv_rsp_if.source rsp_if,
   wsmv_csr_if.sink   csr_if
);

   logic [6:0] volume_ff, volume_in;
   logic       mid_valid;
   logic       mid_ready;
   res_type    mid_data;

   assign csr_if.ready = 1'b1;
   assign volume_in    = (csr_if.valid && csr_if.ready) ? csr_if.volume_percent
                                                        : volume_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff <= VOLUME_RESET;
      end else begin
         volume_ff <= volume_in;
      end
   end

   wsmv_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_if.valid),
      .in_ready   (req_if.ready),
      .data_byte  (req_if.data_byte),
      .file_start (req_if.file_start),
      .file_end   (req_if.file_end),
      .res_valid  (mid_valid),
      .res_ready  (mid_ready),
      .res_data   (mid_data)
   );

   wsmv_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .volume   (volume_ff),
      .in_valid (mid_valid),
      .in_ready (mid_ready),
      .in_data  (mid_data),
      .rsp_if   (rsp_if)
   );

`ifndef SYNTH
   a_volume_write: assert property (@(posedge clock) disable iff (reset)
      csr_if.valid && csr_if.ready |=> volume_ff == $past(csr_if.volume_percent))
      else $error("Volume register did not take the written word.");

   a_report_no_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.kind != KIND_SAMPLE |-> rsp_if.sample == 16'sd0)
      else $error("Header report carries a nonzero sample.");

   a_sample_no_header: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.kind == KIND_SAMPLE |->
         rsp_if.rate_hz == 32'd0 && rsp_if.channels == 16'd0 &&
         rsp_if.chunk_size == 32'd0)
      else $error("Sample word carries header fields.");
`endif

endmodule
